// ===== rtl/core/clr_pkg.sv =====
// ----------------------------------------------------------------------------
// clr_pkg
// Shared constants and types of the CAN line reassembler.
// ----------------------------------------------------------------------------
`default_nettype none

package clr_pkg;

    localparam int LINE_BYTES  = 64;
    localparam int SEQ_BITS    = 7;
    localparam int ADDR_W      = $clog2(LINE_BYTES);

    localparam int ID_W        = 11;
    localparam int LEN_W       = 4;
    localparam int BYTE_W      = 8;
    localparam int EXP_W       = 8;
    localparam int OUT_LEN_W   = 6;
    localparam int PAYLOAD_MAX = 7;
    localparam int PAY_W       = 3;
    localparam int MAX_LEN     = 8;
    localparam int LAST_BIT    = 7;

    localparam logic [ID_W-1:0] RX_ID_RESET = 11'd256;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WRITE,
        ST_EMIT
    } t_state;

endpackage

`default_nettype wire

// ===== rtl/core/clr_if.sv =====
// ----------------------------------------------------------------------------
// clr_frame_if / clr_line_if
// Valid/ready channels for received frames and emitted line bytes.
// ----------------------------------------------------------------------------
`default_nettype none

interface clr_frame_if;
    import clr_pkg::*;

    logic              valid;
    logic              ready;
    logic [ID_W-1:0]   frame_ident;
    logic [LEN_W-1:0]  frame_length;
    logic [BYTE_W-1:0] data_b0;
    logic [BYTE_W-1:0] data_b1;
    logic [BYTE_W-1:0] data_b2;
    logic [BYTE_W-1:0] data_b3;
    logic [BYTE_W-1:0] data_b4;
    logic [BYTE_W-1:0] data_b5;
    logic [BYTE_W-1:0] data_b6;
    logic [BYTE_W-1:0] data_b7;

    modport source (
        output valid, frame_ident, frame_length,
        output data_b0, data_b1, data_b2, data_b3, data_b4, data_b5, data_b6, data_b7,
        input  ready
    );

    modport sink (
        input  valid, frame_ident, frame_length,
        input  data_b0, data_b1, data_b2, data_b3, data_b4, data_b5, data_b6, data_b7,
        output ready
    );
endinterface

interface clr_line_if;
    import clr_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [BYTE_W-1:0]    line_byte;
    logic                 line_end;
    logic [OUT_LEN_W-1:0] line_length;

    modport source (
        output valid, line_byte, line_end, line_length,
        input  ready
    );

    modport sink (
        input  valid, line_byte, line_end, line_length,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/core/clr_line_ram.sv =====
// ----------------------------------------------------------------------------
// clr_line_ram
// Simple dual-port line store, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module clr_line_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 8
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // hold read data between reads
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/core/can_line_reassembler.sv =====
// ----------------------------------------------------------------------------
// can_line_reassembler
// Appends the payload of matching CAN frames to a line store and emits the
// completed line byte by byte on the last frame of a group.
// The frame decision is made in the accept cycle; the payload bytes are then
// written to the store one after another in the write state.
// A last frame with a non-empty line also holds the input until every byte
// of the line has been read from the store, at most one read per cycle and
// slower while the output stalls.
// A completed line leaves at one byte per cycle while the output is ready,
// via the store read and output registers; the read port sets this rate.
// Reset: synchronous, clears fill count, expected sequence, control state and
// loads the identifier register with 0x100; the store itself is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module can_line_reassembler (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_we,
    input  wire logic [clr_pkg::ID_W-1:0]  i_cfg_wdata,
    clr_frame_if.sink                      i_frame,
    clr_line_if.source                     o_line
);
    import clr_pkg::*;

    t_state               r_state, n_state;
    logic [ID_W-1:0]      r_rx_id;
    logic [ADDR_W-1:0]    r_fill, n_fill;
    logic [EXP_W-1:0]     r_exp, n_exp;
    logic [ADDR_W-1:0]    r_wr_addr, n_wr_addr;
    logic [PAY_W-1:0]     r_wr_left, n_wr_left;
    logic                 r_emit, n_emit;
    logic [ADDR_W-1:0]    r_emit_len, n_emit_len;
    logic [ADDR_W-1:0]    r_rd_ptr, n_rd_ptr;
    logic [BYTE_W-1:0]    r_bytes [PAYLOAD_MAX];

    logic                 r_q_valid;
    logic                 r_q_end;
    logic [ADDR_W-1:0]    r_q_len;
    logic                 r_out_valid;
    logic [BYTE_W-1:0]    r_out_byte;
    logic                 r_out_end;
    logic [ADDR_W-1:0]    r_out_len;

    logic                 accept;
    logic                 hit;
    logic [LEN_W-1:0]     len_sat;
    logic [PAY_W-1:0]     payload;
    logic [SEQ_BITS-1:0]  seq;
    logic                 last;
    logic [ADDR_W-1:0]    base_fill;
    logic [EXP_W-1:0]     base_exp;
    logic [ADDR_W:0]      sum_fill;
    logic                 ram_we;
    logic                 ram_re;
    logic [BYTE_W-1:0]    ram_rdata;
    logic                 load_out;
    logic                 rd_last;

    assign accept  = i_frame.valid && i_frame.ready;
    assign hit     = (i_frame.frame_ident == r_rx_id) && (i_frame.frame_length != '0);
    assign len_sat = (i_frame.frame_length > LEN_W'(MAX_LEN)) ? LEN_W'(MAX_LEN)
                                                              : i_frame.frame_length;
    assign payload   = PAY_W'(len_sat - LEN_W'(1));
    assign seq       = i_frame.data_b0[SEQ_BITS-1:0];
    assign last      = i_frame.data_b0[LAST_BIT];
    assign base_fill = (seq == '0) ? '0 : r_fill;
    assign base_exp  = (seq == '0) ? '0 : r_exp;
    assign sum_fill  = {1'b0, base_fill} + (ADDR_W+1)'(payload);

    assign load_out = r_q_valid && (!r_out_valid || o_line.ready);
    assign rd_last  = (r_rd_ptr == r_emit_len - ADDR_W'(1));

    always_comb begin
        n_state    = r_state;
        n_fill     = r_fill;
        n_exp      = r_exp;
        n_wr_addr  = r_wr_addr;
        n_wr_left  = r_wr_left;
        n_emit     = r_emit;
        n_emit_len = r_emit_len;
        n_rd_ptr   = r_rd_ptr;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        i_frame.ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                i_frame.ready = 1'b1;
                if (i_frame.valid && hit) begin
                    if (EXP_W'(seq) != base_exp) begin
                        n_fill = '0;
                        n_exp  = '0;
                    end else if (sum_fill >= (ADDR_W+1)'(LINE_BYTES)) begin
                        n_fill = '0;
                        n_exp  = '0;
                    end else begin
                        n_wr_addr  = base_fill;
                        n_wr_left  = payload;
                        n_emit     = last && (sum_fill[ADDR_W-1:0] != '0);
                        n_emit_len = sum_fill[ADDR_W-1:0];
                        n_rd_ptr   = '0;
                        if (last) begin
                            n_fill = '0;
                            n_exp  = '0;
                        end else begin
                            n_fill = sum_fill[ADDR_W-1:0];
                            n_exp  = base_exp + EXP_W'(1);
                        end
                        if (payload != '0) begin
                            n_state = ST_WRITE;
                        end else if (last && (sum_fill[ADDR_W-1:0] != '0)) begin
                            n_state = ST_EMIT;
                        end
                    end
                end
            end
            ST_WRITE: begin
                ram_we    = 1'b1;
                n_wr_addr = r_wr_addr + ADDR_W'(1);
                n_wr_left = r_wr_left - PAY_W'(1);
                if (r_wr_left == PAY_W'(1)) begin
                    n_state = r_emit ? ST_EMIT : ST_IDLE;
                end
            end
            ST_EMIT: begin
                ram_re = !r_q_valid || load_out;
                if (ram_re) begin
                    n_rd_ptr = r_rd_ptr + ADDR_W'(1);
                    if (rd_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_rx_id     <= RX_ID_RESET;
            r_fill      <= '0;
            r_exp       <= '0;
            r_wr_left   <= '0;
            r_emit      <= 1'b0;
            r_emit_len  <= '0;
            r_rd_ptr    <= '0;
            r_q_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_fill     <= n_fill;
            r_exp      <= n_exp;
            r_wr_left  <= n_wr_left;
            r_emit     <= n_emit;
            r_emit_len <= n_emit_len;
            r_rd_ptr   <= n_rd_ptr;
            if (i_cfg_we) begin
                r_rx_id <= i_cfg_wdata;
            end
            if (ram_re) begin
                r_q_valid <= 1'b1;
            end else if (load_out) begin
                r_q_valid <= 1'b0;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_line.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload shift line and output stages
    always_ff @(posedge i_clk) begin
        r_wr_addr <= n_wr_addr;
        if (accept) begin
            r_bytes[0] <= i_frame.data_b1;
            r_bytes[1] <= i_frame.data_b2;
            r_bytes[2] <= i_frame.data_b3;
            r_bytes[3] <= i_frame.data_b4;
            r_bytes[4] <= i_frame.data_b5;
            r_bytes[5] <= i_frame.data_b6;
            r_bytes[6] <= i_frame.data_b7;
        end else if (ram_we) begin
            for (int k = 0; k < PAYLOAD_MAX - 1; k++) begin
                r_bytes[k] <= r_bytes[k+1];
            end
        end
        if (ram_re) begin
            r_q_end <= rd_last;
            r_q_len <= r_emit_len;
        end
        if (load_out) begin
            r_out_byte <= ram_rdata;
            r_out_end  <= r_q_end;
            r_out_len  <= r_q_len;
        end
    end

    clr_line_ram #(
        .DEPTH (LINE_BYTES),
        .WIDTH (BYTE_W)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wr_addr),
        .i_wdata (r_bytes[0]),
        .i_re    (ram_re),
        .i_raddr (r_rd_ptr),
        .o_rdata (ram_rdata)
    );

    assign o_line.valid       = r_out_valid;
    assign o_line.line_byte   = r_out_byte;
    assign o_line.line_end    = r_out_end;
    assign o_line.line_length = OUT_LEN_W'(r_out_len);

    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ram_we && ram_re))
        else $error("line store written and read in one cycle");

    a_rd_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> (r_rd_ptr < r_emit_len))
        else $error("read pointer beyond line length");

    a_q_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_q_valid && !load_out) |=> r_q_valid)
        else $error("read data dropped before transfer to output");

    a_emit_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($rose(r_state == ST_EMIT)) |-> (r_emit_len != '0))
        else $error("empty line emitted");

endmodule

`default_nettype wire

// ===== tb/sv/tb_can_line_reassembler.sv =====
// ----------------------------------------------------------------------------
// tb_can_line_reassembler
// Drives CAN frames into the line reassembler and checks every emitted line
// byte against an in-bench prediction of the segment reassembly. Directed
// frames cover empty, maximal, restarted, mismatched and ignored groups; the
// random part mixes well-formed groups with noise, broken and overlong groups
// under several identifier settings, with random stalls on both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_can_line_reassembler;
    import clr_pkg::*;

    localparam int LIMIT_CYCLES = 1000000;
    localparam int SETTLE       = 20;

    typedef struct {
        logic [ID_W-1:0]   ident;
        logic [LEN_W-1:0]  length;
        logic [BYTE_W-1:0] data [8];
    } t_can_frame;

    typedef struct packed {
        logic [BYTE_W-1:0]    b;
        logic                 e;
        logic [OUT_LEN_W-1:0] n;
    } t_line_beat;

    class line_checker;
        logic [ID_W-1:0]   rx_id;
        logic [6:0]        fill;
        logic [EXP_W-1:0]  next_seq;
        logic [BYTE_W-1:0] store [LINE_BYTES];
        t_line_beat        pending_bytes [$];
        int                errors;
        int                bytes_seen;

        function new();
            rx_id      = RX_ID_RESET;
            fill       = '0;
            next_seq   = '0;
            errors     = 0;
            bytes_seen = 0;
        endfunction

        function void take_frame(t_can_frame f);
            int                len;
            int                pay;
            int                cnt;
            logic [EXP_W-1:0]  seq;
            logic              last;
            t_line_beat        beat;
            if (f.ident != rx_id || f.length == 0) return;
            len  = (f.length > MAX_LEN) ? MAX_LEN : int'(f.length);
            seq  = EXP_W'(f.data[0][SEQ_BITS-1:0]);
            last = f.data[0][LAST_BIT];
            if (seq == 0) begin
                fill     = '0;
                next_seq = '0;
            end
            if (seq != next_seq) begin
                fill     = '0;
                next_seq = '0;
                return;
            end
            pay = len - 1;
            if (int'(fill) + pay >= LINE_BYTES) begin
                fill     = '0;
                next_seq = '0;
                return;
            end
            for (int i = 0; i < pay; i++) store[int'(fill) + i] = f.data[1 + i];
            fill     = fill + 7'(pay);
            next_seq = next_seq + 1'b1;
            if (!last) return;
            cnt      = int'(fill);
            fill     = '0;
            next_seq = '0;
            for (int i = 0; i < cnt; i++) begin
                beat.b = store[i];
                beat.e = (i + 1 == cnt);
                beat.n = OUT_LEN_W'(cnt);
                pending_bytes.push_back(beat);
            end
        endfunction

        function void check_byte(logic [BYTE_W-1:0] b, logic e, logic [OUT_LEN_W-1:0] n);
            t_line_beat want;
            if (pending_bytes.size() == 0) begin
                $display("%0t unexpected line byte: expected none, actual %h end %b len %0d",
                         $time, b, e, n);
                errors++;
                return;
            end
            want = pending_bytes.pop_front();
            bytes_seen++;
            if (want.b !== b) begin
                $display("%0t line_byte: expected %h, actual %h", $time, want.b, b);
                errors++;
            end
            if (want.e !== e) begin
                $display("%0t line_end: expected %b, actual %b", $time, want.e, e);
                errors++;
            end
            if (want.n !== n) begin
                $display("%0t line_length: expected %0d, actual %0d", $time, want.n, n);
                errors++;
            end
        endfunction
    endclass

    logic            i_clk;
    logic            i_rst_n;
    logic            i_cfg_we;
    logic [ID_W-1:0] i_cfg_wdata;

    clr_frame_if frm ();
    clr_line_if  ln ();

    can_line_reassembler u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_frame     (frm),
        .o_line      (ln)
    );

    line_checker sb;
    int          frames_sent;
    int          cycles = 0;
    int          stall_left = 0;
    bit          calm;
    int          id_seen [4];

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic t_can_frame mk_frame(logic [ID_W-1:0] ident, int len, int hdr, int fillv);
        t_can_frame f;
        f.ident   = ident;
        f.length  = LEN_W'(len);
        f.data[0] = BYTE_W'(hdr);
        for (int i = 1; i < 8; i++)
            f.data[i] = (fillv < 0) ? BYTE_W'($urandom_range(0, 255)) : BYTE_W'(fillv);
        return f;
    endfunction

    function automatic logic [ID_W-1:0] foreign_ident();
        logic [ID_W-1:0] v;
        do v = ID_W'($urandom_range(0, 2047)); while (v == sb.rx_id);
        return v;
    endfunction

    // Sink side: check on acceptance, then decide the next ready.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("tb_can_line_reassembler: done, errors");
            $finish;
        end
        if (i_rst_n && ln.valid && ln.ready)
            sb.check_byte(ln.line_byte, ln.line_end, ln.line_length);
        if (stall_left > 0) begin
            ln.ready   <= 1'b0;
            stall_left  = stall_left - 1;
        end else begin
            ln.ready   <= 1'b1;
            stall_left  = pick_gap();
        end
    end

    task automatic push_frame(input t_can_frame f);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            frm.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        frm.valid        <= 1'b1;
        frm.frame_ident  <= f.ident;
        frm.frame_length <= f.length;
        frm.data_b0      <= f.data[0];
        frm.data_b1      <= f.data[1];
        frm.data_b2      <= f.data[2];
        frm.data_b3      <= f.data[3];
        frm.data_b4      <= f.data[4];
        frm.data_b5      <= f.data[5];
        frm.data_b6      <= f.data[6];
        frm.data_b7      <= f.data[7];
        do @(posedge i_clk); while (!frm.ready);
        sb.take_frame(f);
        frames_sent++;
    endtask

    task automatic drain();
        frm.valid <= 1'b0;
        while (sb.pending_bytes.size() > 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic load_ident(input logic [ID_W-1:0] v);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.rx_id     = v;
    endtask

    // Well-formed group of nf frames, optionally with foreign frames mixed in.
    task automatic send_group(input int nf, input bit noisy, input int max_len);
        int len;
        int hdr;
        for (int s = 0; s < nf; s++) begin
            if (noisy && $urandom_range(0, 3) == 0)
                push_frame(mk_frame(foreign_ident(), $urandom_range(0, 15),
                                    $urandom_range(0, 255), -1));
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 15) : $urandom_range(1, max_len);
            hdr = (s % 128) | ((s == nf - 1) ? 'h80 : 0);
            push_frame(mk_frame(sb.rx_id, len, hdr, -1));
        end
    endtask

    task automatic run_random(input int n_items);
        int r;
        int stop_at;
        stop_at = frames_sent + n_items;
        while (frames_sent < stop_at) begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
                send_group($urandom_range(1, 4), r < 15, 8);
            end else if (r < 66) begin
                send_group($urandom_range(5, 9), 1'b0, 8);
            end else if (r < 74) begin
                push_frame(mk_frame(foreign_ident(), $urandom_range(0, 15),
                                    $urandom_range(0, 255), -1));
            end else if (r < 79) begin
                push_frame(mk_frame(sb.rx_id, 0, $urandom_range(0, 255), -1));
            end else if (r < 87) begin
                // broken group: skip a sequence number
                push_frame(mk_frame(sb.rx_id, $urandom_range(1, 8), 0, -1));
                push_frame(mk_frame(sb.rx_id, $urandom_range(1, 8),
                                    $urandom_range(2, 127) | ($urandom_range(0, 1) << 7), -1));
            end else if (r < 92) begin
                // overlong group
                for (int s = 0; s < 10; s++)
                    push_frame(mk_frame(sb.rx_id, 8, s | ((s == 9) ? 'h80 : 0), -1));
            end else begin
                push_frame(mk_frame(sb.rx_id, $urandom_range(0, 15), $urandom_range(0, 255), -1));
            end
        end
    endtask

    initial begin
        sb               = new();
        frames_sent      = 0;
        calm             = 1'b0;
        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_wdata     <= '0;
        frm.valid       <= 1'b0;
        frm.frame_ident  <= '0;
        frm.frame_length <= '0;
        frm.data_b0      <= '0;
        frm.data_b1      <= '0;
        frm.data_b2      <= '0;
        frm.data_b3      <= '0;
        frm.data_b4      <= '0;
        frm.data_b5      <= '0;
        frm.data_b6      <= '0;
        frm.data_b7      <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part under the reset identifier.
        push_frame(mk_frame(RX_ID_RESET, 1, 'h80, -1));
        push_frame(mk_frame(RX_ID_RESET, 8, 'h00, 'h00));
        push_frame(mk_frame(RX_ID_RESET, 8, 'h81, 'hFF));
        push_frame(mk_frame(RX_ID_RESET, 3, 'h00, -1));
        push_frame(mk_frame(11'd0, 8, 'h81, -1));
        push_frame(mk_frame(RX_ID_RESET, 0, 'h81, -1));
        push_frame(mk_frame(11'd2047, 8, 'h81, -1));
        push_frame(mk_frame(RX_ID_RESET, 15, 'h81, -1));
        push_frame(mk_frame(RX_ID_RESET, 4, 'h00, -1));
        push_frame(mk_frame(RX_ID_RESET, 4, 'h82, -1));
        push_frame(mk_frame(RX_ID_RESET, 4, 'h81, -1));
        push_frame(mk_frame(RX_ID_RESET, 5, 'h00, -1));
        push_frame(mk_frame(RX_ID_RESET, 3, 'h80, -1));
        for (int s = 0; s < 9; s++)
            push_frame(mk_frame(RX_ID_RESET, 8, s | ((s == 8) ? 'h80 : 0), -1));
        id_seen[0] = int'(RX_ID_RESET);

        load_ident(11'd0);
        id_seen[1] = 0;
        run_random(20);

        load_ident(11'd2047);
        id_seen[2] = 2047;
        calm = 1'b1;
        run_random(15);
        calm = 1'b0;
        run_random(10);

        load_ident(ID_W'($urandom_range(1, 2046)));
        id_seen[3] = int'(sb.rx_id);
        run_random(25);

        drain();
        $display("%0d frames sent, %0d line bytes checked", frames_sent, sb.bytes_seen);
        $display("identifier settings %0d, %0d, %0d, %0d", id_seen[0], id_seen[1],
                 id_seen[2], id_seen[3]);
        if (sb.errors == 0 && sb.pending_bytes.size() == 0) begin
            $display("tb_can_line_reassembler: done, clean");
        end else begin
            $display("tb_can_line_reassembler: done, errors");
        end
        $finish;
    end

endmodule

`default_nettype wire
